// ===== rtl/cmc_pkg.sv =====
// ----------------------------------------------------------------------------
// CNF model checker package
// Shared types, codes and constants for the model checker blocks.
// ----------------------------------------------------------------------------
package cmc_pkg;

  // Default number of variables the assignment store can hold.
  localparam int unsigned MaxVarsDefault = 4096;

  // Field and register widths.
  localparam int unsigned ReqTypeW   = 2;
  localparam int unsigned LiteralW   = 14;
  localparam int unsigned NumVarsW   = 13;
  localparam int unsigned ClauseCntW = 32;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 32;

  // Queue depths between the parts.
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned ResDepth = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_NUM_VARS      = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_EXPECT_CLAUSE = 1'd1;

  // Request types on the input channel.
  typedef enum logic [ReqTypeW-1:0] {
    REQ_MODEL  = 2'd0,
    REQ_CLAUSE = 2'd1,
    REQ_FINISH = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // Status codes reported with each result.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_CONTRA   = 3'd2,
    ST_UNSAT    = 3'd3,
    ST_TOOMANY  = 3'd4,
    ST_UNTERM   = 3'd5,
    ST_MISMATCH = 3'd6
  } status_e;

  // Assignment store entry values.
  localparam logic [1:0] VAL_NONE  = 2'd0;
  localparam logic [1:0] VAL_TRUE  = 2'd1;
  localparam logic [1:0] VAL_FALSE = 2'd2;

  // Operations handed from the front part to the back part.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_RANGE,
    OP_ASSIGN,
    OP_CHECK,
    OP_CLOSE,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e  op;
    logic neg;
  } cmd_t;

  typedef struct packed {
    status_e               status;
    logic [ClauseCntW-1:0] clause_count;
    logic                  model_valid;
  } res_t;

  // Back part states.
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EVAL
  } back_state_e;

endpackage

// ===== rtl/cmc_fifo.sv =====
// ----------------------------------------------------------------------------
// CNF model checker queue
// Small register queue used between the front and back parts and at the
// result side.
// ----------------------------------------------------------------------------
module cmc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] data_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = data_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/cmc_front.sv =====
// ----------------------------------------------------------------------------
// CNF model checker front part
// Decodes an incoming request into a command: literal magnitude and
// polarity, range check against the variable count, and operation class.
// ----------------------------------------------------------------------------
module cmc_front #(
  parameter int unsigned MaxVars = cmc_pkg::MaxVarsDefault,
  parameter int unsigned AddrW   = $clog2(MaxVars + 1)
) (
  input  logic [cmc_pkg::ReqTypeW-1:0] req_type_i,
  input  logic [cmc_pkg::LiteralW-1:0] literal_i,
  input  logic [cmc_pkg::NumVarsW-1:0] num_vars_i,
  output cmc_pkg::cmd_t                cmd_o,
  output logic [AddrW-1:0]             addr_o
);

  localparam logic [31:0] MaxLimit = 32'(MaxVars);

  logic                         neg;
  logic [cmc_pkg::LiteralW-1:0] mag;
  logic [31:0]                  mag_w;
  logic [31:0]                  nv_w;
  logic [31:0]                  limit;
  logic                         out_of_range;
  cmc_pkg::req_e                req;

  // Literal magnitude and polarity; the most negative code maps to 8192.
  assign neg   = literal_i[cmc_pkg::LiteralW-1];
  assign mag   = neg ? (~literal_i + 1'b1) : literal_i;
  assign mag_w = 32'(mag);

  // Effective variable count is the configured count capped by the store size.
  assign nv_w         = 32'(num_vars_i);
  assign limit        = (nv_w > MaxLimit) ? MaxLimit : nv_w;
  assign out_of_range = (mag_w > limit);
  assign addr_o       = mag_w[AddrW-1:0];

  assign req = cmc_pkg::req_e'(req_type_i);

  // Operation class.
  always_comb begin
    cmd_o.neg = neg;
    case (req)
      cmc_pkg::REQ_MODEL: begin
        if (out_of_range) begin
          cmd_o.op = cmc_pkg::OP_RANGE;
        end else if (mag == '0) begin
          cmd_o.op = cmc_pkg::OP_NOP;
        end else begin
          cmd_o.op = cmc_pkg::OP_ASSIGN;
        end
      end
      cmc_pkg::REQ_CLAUSE: begin
        if (out_of_range) begin
          cmd_o.op = cmc_pkg::OP_RANGE;
        end else if (mag == '0) begin
          cmd_o.op = cmc_pkg::OP_CLOSE;
        end else begin
          cmd_o.op = cmc_pkg::OP_CHECK;
        end
      end
      cmc_pkg::REQ_FINISH: cmd_o.op = cmc_pkg::OP_FINISH;
      default:             cmd_o.op = cmc_pkg::OP_NOP;
    endcase
  end

endmodule

// ===== rtl/cmc_back.sv =====
// ----------------------------------------------------------------------------
// CNF model checker back part
// Owns the assignment store and the clause state. Clears the store after
// reset, then carries out each command as a store read followed by
// evaluation with an optional store write and a result.
// ----------------------------------------------------------------------------
module cmc_back #(
  parameter int unsigned MaxVars = cmc_pkg::MaxVarsDefault,
  parameter int unsigned AddrW   = $clog2(MaxVars + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [cmc_pkg::ClauseCntW-1:0] expected_clauses_i,
  // Command queue side.
  input  logic                           cmd_empty_i,
  input  cmc_pkg::cmd_t                  cmd_i,
  input  logic [AddrW-1:0]               addr_i,
  output logic                           cmd_pop_o,
  // Result queue side.
  input  logic                           res_full_i,
  output logic                           res_push_o,
  output cmc_pkg::res_t                  res_o,
  output logic                           clearing_o
);

  localparam int unsigned Entries = MaxVars + 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MaxVars);

  cmc_pkg::back_state_e           state_q, state_d;
  logic [AddrW-1:0]               clr_q, clr_d;
  cmc_pkg::cmd_t                  cmd_q, cmd_d;
  logic [AddrW-1:0]               addr_q, addr_d;
  logic                           sat_q, sat_d;
  logic                           pend_q, pend_d;
  logic [cmc_pkg::ClauseCntW-1:0] count_q, count_d;
  cmc_pkg::status_e               err_q, err_d;

  logic [1:0]       store_q [Entries];
  logic [1:0]       rdata_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [1:0]       mem_wdata;
  logic [1:0]       pol;
  logic             valid;

  assign pol        = cmd_q.neg ? cmc_pkg::VAL_FALSE : cmc_pkg::VAL_TRUE;
  assign clearing_o = (state_q == cmc_pkg::BK_CLEAR);

  // Next state, store access and result.
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cmd_d      = cmd_q;
    addr_d     = addr_q;
    sat_d      = sat_q;
    pend_d     = pend_q;
    count_d    = count_q;
    err_d      = err_q;
    mem_we     = 1'b0;
    mem_waddr  = addr_q;
    mem_wdata  = pol;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    valid      = 1'b0;

    case (state_q)
      cmc_pkg::BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = cmc_pkg::VAL_NONE;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LastAddr) begin
          state_d = cmc_pkg::BK_IDLE;
        end
      end
      cmc_pkg::BK_IDLE: begin
        // The read of the store is issued from the queue head address.
        if (!cmd_empty_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          addr_d    = addr_i;
          state_d   = cmc_pkg::BK_EVAL;
        end
      end
      cmc_pkg::BK_EVAL: begin
        res_push_o = 1'b1;
        state_d    = cmc_pkg::BK_IDLE;
        if (err_q == cmc_pkg::ST_OK) begin
          case (cmd_q.op)
            cmc_pkg::OP_RANGE: err_d = cmc_pkg::ST_RANGE;
            cmc_pkg::OP_ASSIGN: begin
              if (rdata_q != cmc_pkg::VAL_NONE && rdata_q != pol) begin
                err_d = cmc_pkg::ST_CONTRA;
              end else begin
                mem_we = 1'b1;
              end
            end
            cmc_pkg::OP_CHECK: begin
              if (rdata_q == pol) begin
                sat_d = 1'b1;
              end
              pend_d = 1'b1;
            end
            cmc_pkg::OP_CLOSE: begin
              // Count advances first; too many is checked before unsatisfied.
              if (count_q == '1) begin
                err_d = cmc_pkg::ST_TOOMANY;
              end else begin
                count_d = count_q + 1'b1;
                if (count_q >= expected_clauses_i) begin
                  err_d = cmc_pkg::ST_TOOMANY;
                end else if (!sat_q) begin
                  err_d = cmc_pkg::ST_UNSAT;
                end else begin
                  sat_d  = 1'b0;
                  pend_d = 1'b0;
                end
              end
            end
            cmc_pkg::OP_FINISH: begin
              if (pend_q) begin
                err_d = cmc_pkg::ST_UNTERM;
              end else if (count_q != expected_clauses_i) begin
                err_d = cmc_pkg::ST_MISMATCH;
              end else begin
                valid = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      default: state_d = cmc_pkg::BK_IDLE;
    endcase

    res_o.status       = err_d;
    res_o.clause_count = count_d;
    res_o.model_valid  = valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cmc_pkg::BK_CLEAR;
      clr_q   <= '0;
      sat_q   <= 1'b0;
      pend_q  <= 1'b0;
      count_q <= '0;
      err_q   <= cmc_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      sat_q   <= sat_d;
      pend_q  <= pend_d;
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

  // Command registers for the item under evaluation.
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    addr_q <= addr_d;
  end

  // Assignment store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= store_q[addr_i];
  end

endmodule

// ===== rtl/cnf_model_checker.sv =====
// ----------------------------------------------------------------------------
// CNF model checker
// Checks a SAT model against a CNF formula, one literal per request.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------------------------
//  request  | push / full      | req_type_i, literal_i
//  result   | empty / pop      | status_o, clause_count_o, model_valid_o
//  config   | cfg_we_i         | cfg_idx_i, cfg_wdata_i
//
// In the back part each request goes through an assignment store read, then
// evaluation with an optional store write; a new request is taken only when
// the back part is idle. The store has a single read and a single write port.
// After reset the store is cleared one entry a cycle, entries 0 to MaxVars,
// while full stays high; configuration writes are taken meanwhile.
// Two-entry queues sit behind the front decode and in front of the results,
// so either side can stall without blocking the other.
// ----------------------------------------------------------------------------
module cnf_model_checker #(
  parameter int unsigned MaxVars = cmc_pkg::MaxVarsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration.
  input  logic                           cfg_we_i,
  input  logic [cmc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [cmc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // Requests.
  input  logic                           push,
  output logic                           full,
  input  logic [cmc_pkg::ReqTypeW-1:0]   req_type_i,
  input  logic [cmc_pkg::LiteralW-1:0]   literal_i,
  // Results.
  output logic                           empty,
  input  logic                           pop,
  output logic [2:0]                     status_o,
  output logic [cmc_pkg::ClauseCntW-1:0] clause_count_o,
  output logic                           model_valid_o
);

  localparam int unsigned AddrW = $clog2(MaxVars + 1);
  localparam int unsigned CmdW  = AddrW + $bits(cmc_pkg::cmd_t);
  localparam int unsigned ResW  = $bits(cmc_pkg::res_t);

  logic [cmc_pkg::NumVarsW-1:0]   num_vars_q;
  logic [cmc_pkg::ClauseCntW-1:0] expected_q;

  cmc_pkg::cmd_t     fr_cmd;
  logic [AddrW-1:0]  fr_addr;
  logic              cmdq_full, cmdq_empty, cmdq_pop;
  logic [CmdW-1:0]   cmdq_rdata;
  cmc_pkg::cmd_t     bk_cmd;
  logic [AddrW-1:0]  bk_addr;
  logic              clearing;
  logic              resq_full, resq_push;
  cmc_pkg::res_t     bk_res, out_res;
  logic [ResW-1:0]   resq_rdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vars_q <= '0;
      expected_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cmc_pkg::CFG_NUM_VARS:      num_vars_q <= cfg_wdata_i[cmc_pkg::NumVarsW-1:0];
        cmc_pkg::CFG_EXPECT_CLAUSE: expected_q <= cfg_wdata_i[cmc_pkg::ClauseCntW-1:0];
        default: ;
      endcase
    end
  end

  // Request decode.
  cmc_front #(
    .MaxVars (MaxVars),
    .AddrW   (AddrW)
  ) u_front (
    .req_type_i (req_type_i),
    .literal_i  (literal_i),
    .num_vars_i (num_vars_q),
    .cmd_o      (fr_cmd),
    .addr_o     (fr_addr)
  );

  assign full = cmdq_full || clearing;

  // Command queue between front and back.
  cmc_fifo #(
    .Width (CmdW),
    .Depth (cmc_pkg::CmdDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && !full),
    .wdata_i ({fr_addr, fr_cmd}),
    .full_o  (cmdq_full),
    .pop_i   (cmdq_pop),
    .rdata_o (cmdq_rdata),
    .empty_o (cmdq_empty)
  );

  assign bk_addr = cmdq_rdata[CmdW-1 -: AddrW];
  assign bk_cmd  = cmc_pkg::cmd_t'(cmdq_rdata[$bits(cmc_pkg::cmd_t)-1:0]);

  // Store owner and executor.
  cmc_back #(
    .MaxVars (MaxVars),
    .AddrW   (AddrW)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .expected_clauses_i (expected_q),
    .cmd_empty_i        (cmdq_empty),
    .cmd_i              (bk_cmd),
    .addr_i             (bk_addr),
    .cmd_pop_o          (cmdq_pop),
    .res_full_i         (resq_full),
    .res_push_o         (resq_push),
    .res_o              (bk_res),
    .clearing_o         (clearing)
  );

  // Result queue.
  cmc_fifo #(
    .Width (ResW),
    .Depth (cmc_pkg::ResDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (resq_push),
    .wdata_i (bk_res),
    .full_o  (resq_full),
    .pop_i   (pop),
    .rdata_o (resq_rdata),
    .empty_o (empty)
  );

  assign out_res        = cmc_pkg::res_t'(resq_rdata);
  assign status_o       = out_res.status;
  assign clause_count_o = out_res.clause_count;
  assign model_valid_o  = out_res.model_valid;

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// CNF model checker testbench
// Streams model and clause literals into the checker through its request
// queue. A predictor in this file tracks the assignment store, the clause
// flags, the clause count and the sticky error, and every popped result is
// compared field by field with its prediction. One reset covers the run, so
// the formula phases are kept error free and a single randomly chosen error
// is provoked at the end, followed by a few requests that must report it.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cmc_pkg::*;

  localparam int unsigned VarCap = MaxVarsDefault;

  // Directed stimulus row: a register write or a request with an optional
  // expectation typed in by hand.
  typedef struct {
    bit                   is_cfg;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  val;
    req_e                 rt;
    int                   lit;
    bit                   typed;
    status_e              st;
    bit                   vld;
  } dir_row_t;

  logic                   clk       = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx   = CFG_NUM_VARS;
  logic [CfgDataW-1:0]    cfg_wdata = '0;
  logic                   push      = 1'b0;
  logic                   full;
  logic [ReqTypeW-1:0]    req_type  = REQ_NONE;
  logic [LiteralW-1:0]    literal   = '0;
  logic                   empty;
  logic                   pop       = 1'b0;
  logic [2:0]             status_o;
  logic [ClauseCntW-1:0]  clause_count_o;
  logic                   model_valid_o;

  // Hand-typed expectation that travels alongside the request.
  logic                   row_typed  = 1'b0;
  status_e                row_status = ST_OK;
  logic                   row_valid  = 1'b0;

  // Predictor state and its copy of the registers.
  logic [1:0]             pv_store [0:VarCap];
  logic [NumVarsW-1:0]    pv_num_vars = '0;
  logic [ClauseCntW-1:0]  pv_expect   = '0;
  logic [ClauseCntW-1:0]  pv_seen     = '0;
  logic                   pv_sat      = 1'b0;
  logic                   pv_pending  = 1'b0;
  status_e                pv_err      = ST_OK;

  res_t                   verdicts_due [$];
  res_t                   verdict_in;
  res_t                   verdict_out;
  int                     n_fail = 0;

  // Stimulus side: the hidden solution and what has been sent of it.
  bit                     sol_neg [1:VarCap];
  bit                     gen_set [0:VarCap];
  logic [ClauseCntW-1:0]  gen_seen = '0;
  int                     n_items  = 0;
  int                     send_idle_pct = 0;
  int                     pop_stall_pct = 0;

  dir_row_t               dir_tbl [27];
  status_e                fail_kinds [6] = '{ST_RANGE, ST_CONTRA, ST_UNSAT,
                                             ST_TOOMANY, ST_UNTERM, ST_MISMATCH};

  cnf_model_checker u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .push           (push),
    .full           (full),
    .req_type_i     (req_type),
    .literal_i      (literal),
    .empty          (empty),
    .pop            (pop),
    .status_o       (status_o),
    .clause_count_o (clause_count_o),
    .model_valid_o  (model_valid_o)
  );

  always #4 clk = ~clk;

  // Works out the result of one accepted request and advances the state.
  function automatic res_t judge_item(input logic [1:0] rt, input logic [13:0] lit);
    logic [13:0]         mag;
    logic [1:0]          pol;
    logic [NumVarsW-1:0] lim;
    logic                ok;
    res_t                r;
    mag = lit[13] ? (~lit + 14'd1) : lit;
    pol = lit[13] ? VAL_FALSE : VAL_TRUE;
    lim = (pv_num_vars > NumVarsW'(VarCap)) ? NumVarsW'(VarCap) : pv_num_vars;
    ok  = 1'b0;
    if (pv_err == ST_OK && rt != REQ_NONE) begin
      if (rt == REQ_FINISH) begin
        if (pv_pending) begin
          pv_err = ST_UNTERM;
        end else if (pv_seen != pv_expect) begin
          pv_err = ST_MISMATCH;
        end else begin
          ok = 1'b1;
        end
      end else if (mag > 14'(lim)) begin
        pv_err = ST_RANGE;
      end else if (rt == REQ_MODEL) begin
        // A model literal may repeat a value but never flip it.
        if (mag != '0) begin
          if (pv_store[mag] != VAL_NONE && pv_store[mag] != pol) begin
            pv_err = ST_CONTRA;
          end else begin
            pv_store[mag] = pol;
          end
        end
      end else if (mag == '0) begin
        // Closing a clause: count first, then the too-many and unsatisfied checks.
        if (pv_seen == '1) begin
          pv_err = ST_TOOMANY;
        end else begin
          pv_seen = pv_seen + 1'b1;
          if (pv_seen > pv_expect) begin
            pv_err = ST_TOOMANY;
          end else if (!pv_sat) begin
            pv_err = ST_UNSAT;
          end else begin
            pv_sat     = 1'b0;
            pv_pending = 1'b0;
          end
        end
      end else begin
        if (pv_store[mag] == pol) pv_sat = 1'b1;
        pv_pending = 1'b1;
      end
    end
    r.status       = pv_err;
    r.clause_count = pv_seen;
    r.model_valid  = ok;
    return r;
  endfunction

  // Register writes, accepted requests and popped results, all seen at the edge.
  always @(posedge clk) begin
    if (rst_ni) begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_NUM_VARS: begin
            pv_num_vars = cfg_wdata[NumVarsW-1:0];
          end
          default: begin
            pv_expect = cfg_wdata;
          end
        endcase
      end
      if (push && !full) begin
        verdict_in = judge_item(req_type, literal);
        if (row_typed) begin
          verdict_in.status      = row_status;
          verdict_in.model_valid = row_valid;
        end
        verdicts_due.push_back(verdict_in);
      end
      if (pop && !empty) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t ns: result with nothing expected, status %0d count %0d",
                   $time, status_o, clause_count_o);
          n_fail++;
        end else begin
          verdict_out = verdicts_due.pop_front();
          if (status_o != verdict_out.status) begin
            $display("%0t ns: status expected %0d actual %0d",
                     $time, verdict_out.status, status_o);
            n_fail++;
          end
          if (clause_count_o != verdict_out.clause_count) begin
            $display("%0t ns: clause_count expected %0d actual %0d",
                     $time, verdict_out.clause_count, clause_count_o);
            n_fail++;
          end
          if (model_valid_o != verdict_out.model_valid) begin
            $display("%0t ns: model_valid expected %0d actual %0d",
                     $time, verdict_out.model_valid, model_valid_o);
            n_fail++;
          end
        end
      end
    end
  end

  // The result side pops at random.
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= pop_stall_pct);
    end
  end

  function automatic dir_row_t req_row(input req_e rt, input int lit);
    dir_row_t r;
    r = '{is_cfg: 1'b0, idx: CFG_NUM_VARS, val: '0, rt: rt, lit: lit,
          typed: 1'b0, st: ST_OK, vld: 1'b0};
    return r;
  endfunction

  function automatic dir_row_t typed_row(input req_e rt, input int lit,
                                         input status_e st, input bit vld);
    dir_row_t r;
    r = '{is_cfg: 1'b0, idx: CFG_NUM_VARS, val: '0, rt: rt, lit: lit,
          typed: 1'b1, st: st, vld: vld};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CfgIdxW-1:0] idx,
                                       input logic [CfgDataW-1:0] val);
    dir_row_t r;
    r = '{is_cfg: 1'b1, idx: idx, val: val, rt: REQ_NONE, lit: 0,
          typed: 1'b0, st: ST_OK, vld: 1'b0};
    return r;
  endfunction

  function automatic int lit_of(input int v, input bit neg);
    return neg ? -v : v;
  endfunction

  // Presents one request and holds it until the checker takes it.
  task automatic send_req(input req_e rt, input int lit, input bit typed = 1'b0,
                          input status_e tst = ST_OK, input bit tvld = 1'b0);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    req_type   <= rt;
    literal    <= 14'(lit);
    row_typed  <= typed;
    row_status <= tst;
    row_valid  <= tvld;
    do @(posedge clk); while (full);
  endtask

  // Stops sending and waits until every result has been popped.
  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk); while (verdicts_due.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic assign_var(input int v);
    send_req(REQ_MODEL, lit_of(v, sol_neg[v]));
    gen_set[v] = 1'b1;
    n_items++;
  endtask

  // Ignored requests sprinkled into the stream.
  task automatic maybe_noise();
    if ($urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 1) != 0) begin
        send_req(REQ_NONE, int'($urandom_range(0, 16383)));
      end else begin
        send_req(REQ_MODEL, 0);
      end
    end
  endtask

  // One clause with at least one literal that the model makes true.
  task automatic send_clause(input int lim);
    int k;
    int pos;
    int sv;
    k   = $urandom_range(1, 4);
    pos = $urandom_range(0, k - 1);
    sv  = $urandom_range(1, lim);
    for (int i = 0; i < k; i++) begin
      if (i == pos) begin
        if (!gen_set[sv]) assign_var(sv);
        send_req(REQ_CLAUSE, lit_of(sv, sol_neg[sv]));
      end else begin
        send_req(REQ_CLAUSE, lit_of($urandom_range(1, lim), 1'($urandom_range(0, 1))));
      end
      n_items++;
      maybe_noise();
    end
    send_req(REQ_CLAUSE, 0);
    n_items++;
    gen_seen = gen_seen + 1'b1;
  endtask

  // Run limit.
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int      nv;
    int      lim;
    int      ncl;
    int      nmod;
    int      v;
    int      phase;
    int      sel;
    bit      open_end;
    req_e    rt;
    status_e fail_kind;

    foreach (pv_store[i]) pv_store[i] = VAL_NONE;
    foreach (gen_set[i]) gen_set[i] = 1'b0;
    foreach (sol_neg[i]) sol_neg[i] = 1'($urandom_range(0, 1));

    dir_tbl = '{
      typed_row(REQ_FINISH, 0, ST_OK, 1'b1),
      typed_row(REQ_NONE, -1, ST_OK, 1'b0),
      typed_row(REQ_MODEL, 0, ST_OK, 1'b0),
      cfg_row(CFG_NUM_VARS, 32'd4096),
      cfg_row(CFG_EXPECT_CLAUSE, 32'hFFFF_FFFF),
      typed_row(REQ_MODEL, 4096, ST_OK, 1'b0),
      typed_row(REQ_MODEL, -1, ST_OK, 1'b0),
      typed_row(REQ_MODEL, 2, ST_OK, 1'b0),
      typed_row(REQ_MODEL, 4096, ST_OK, 1'b0),
      req_row(REQ_CLAUSE, -4096),
      req_row(REQ_CLAUSE, 3),
      req_row(REQ_CLAUSE, -1),
      req_row(REQ_CLAUSE, 0),
      req_row(REQ_CLAUSE, 2),
      req_row(REQ_CLAUSE, 0),
      req_row(REQ_MODEL, 5),
      req_row(REQ_CLAUSE, 5),
      req_row(REQ_CLAUSE, 0),
      cfg_row(CFG_EXPECT_CLAUSE, 32'd3),
      typed_row(REQ_NONE, 4095, ST_OK, 1'b0),
      typed_row(REQ_FINISH, 0, ST_OK, 1'b1),
      cfg_row(CFG_NUM_VARS, 32'd8191),
      cfg_row(CFG_EXPECT_CLAUSE, 32'd4),
      req_row(REQ_MODEL, -4095),
      req_row(REQ_CLAUSE, -4095),
      req_row(REQ_CLAUSE, 0),
      typed_row(REQ_FINISH, 0, ST_OK, 1'b1)
    };

    repeat (9) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed part; the model rows also seed the hidden solution.
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_cfg) begin
        wait_drained();
        write_cfg(dir_tbl[i].idx, dir_tbl[i].val);
      end else begin
        send_req(dir_tbl[i].rt, dir_tbl[i].lit, dir_tbl[i].typed, dir_tbl[i].st,
                 dir_tbl[i].vld);
        if (dir_tbl[i].rt == REQ_MODEL && dir_tbl[i].lit != 0) begin
          v = (dir_tbl[i].lit < 0) ? -dir_tbl[i].lit : dir_tbl[i].lit;
          sol_neg[v] = (dir_tbl[i].lit < 0);
          gen_set[v] = 1'b1;
        end
        if (dir_tbl[i].rt == REQ_CLAUSE && dir_tbl[i].lit == 0) begin
          gen_seen = gen_seen + 1'b1;
        end
      end
    end

    // Random formula phases, each declaring exactly what it sends unless left open.
    phase = 0;
    while (n_items < 1600) begin
      wait_drained();
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          pop_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 80;
          pop_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          pop_stall_pct = 80;
        end
        default: begin
          send_idle_pct = 16;
          pop_stall_pct = 16;
        end
      endcase

      sel = $urandom_range(0, 19);
      case (sel)
        0:       nv = 0;
        1:       nv = 1;
        2:       nv = VarCap;
        3:       nv = 8191;
        4:       nv = $urandom_range(VarCap + 1, 8190);
        default: nv = $urandom_range(2, 48);
      endcase
      lim      = (nv > VarCap) ? VarCap : nv;
      ncl      = (lim == 0) ? 0 : $urandom_range(1, 12);
      open_end = ($urandom_range(0, 7) == 0);

      write_cfg(CFG_NUM_VARS, nv);
      write_cfg(CFG_EXPECT_CLAUSE, open_end ? 32'hFFFF_FFFF : gen_seen + ncl);

      nmod = (lim == 0) ? 0 : $urandom_range(0, (lim < 24) ? lim : 24);
      repeat (nmod) begin
        assign_var($urandom_range(1, lim));
        maybe_noise();
      end
      if (lim == 0) begin
        send_req(REQ_MODEL, 0);
        send_req(REQ_NONE, int'($urandom_range(0, 16383)));
      end
      repeat (ncl) begin
        send_clause(lim);
        // Model literals between clauses just extend the store.
        if ($urandom_range(0, 3) == 0) assign_var($urandom_range(1, lim));
      end
      if (!open_end) begin
        send_req(REQ_FINISH, 0);
        n_items++;
      end
      phase++;
    end

    // Provoke one error, then check that it sticks.
    wait_drained();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    fail_kind = fail_kinds[$urandom_range(0, 5)];
    write_cfg(CFG_NUM_VARS, 32'd64);
    write_cfg(CFG_EXPECT_CLAUSE, (fail_kind == ST_TOOMANY) ? gen_seen : gen_seen + 1'b1);
    v = $urandom_range(1, 64);
    if (!gen_set[v]) assign_var(v);
    case (fail_kind)
      ST_RANGE: begin
        rt = ($urandom_range(0, 1) != 0) ? REQ_MODEL : REQ_CLAUSE;
        send_req(rt, lit_of($urandom_range(65, VarCap), 1'($urandom_range(0, 1))), 1'b1,
                 ST_RANGE);
      end
      ST_CONTRA: begin
        send_req(REQ_MODEL, lit_of(v, !sol_neg[v]), 1'b1, ST_CONTRA);
      end
      ST_UNSAT: begin
        send_req(REQ_CLAUSE, lit_of(v, !sol_neg[v]));
        send_req(REQ_CLAUSE, 0, 1'b1, ST_UNSAT);
      end
      ST_TOOMANY: begin
        send_req(REQ_CLAUSE, lit_of(v, sol_neg[v]));
        send_req(REQ_CLAUSE, 0, 1'b1, ST_TOOMANY);
      end
      ST_UNTERM: begin
        send_req(REQ_CLAUSE, lit_of(v, sol_neg[v]));
        send_req(REQ_FINISH, 0, 1'b1, ST_UNTERM);
      end
      default: begin
        send_req(REQ_FINISH, 0, 1'b1, ST_MISMATCH);
      end
    endcase
    repeat (6) begin
      case ($urandom_range(0, 3))
        0:       rt = REQ_MODEL;
        1:       rt = REQ_CLAUSE;
        2:       rt = REQ_FINISH;
        default: rt = REQ_NONE;
      endcase
      send_req(rt, int'($urandom_range(0, 128)) - 64, 1'b1, fail_kind);
    end

    // Let any stray result show up before the verdict.
    wait_drained();
    repeat (16) @(posedge clk);
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
